// ----- design/ubx_frame_parser_defines.svh -----
// assertion macros used by the checker file
`ifndef UBX_FRAME_PARSER_DEFINES_SVH
`define UBX_FRAME_PARSER_DEFINES_SVH

// same-cycle implication, masked while reset is asserted
`define UBX_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked while reset is asserted
`define UBX_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that is checked through reset too
`define UBX_ASSERT_RESET(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/ubx_pkg.sv -----
`default_nettype none

package ubx_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'hb5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_PAYLOAD = 3'd1,
        EV_GOOD    = 3'd2,
        EV_BAD     = 3'd3,
        EV_REJECT  = 3'd4
    } t_event;

    typedef struct packed {
        t_event      evt;
        logic [7:0]  msg_class;
        logic [7:0]  msg_ident;
        logic [5:0]  payload_len;
        logic [7:0]  payload_byte;
        logic [5:0]  payload_index;
    } t_result;

endpackage

`default_nettype wire

// ----- design/ubx_parse_core.sv -----
`default_nettype none

module ubx_parse_core #(
    parameter int MAX_PAYLOAD = 62
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire logic [7:0]       i_rx_byte,
    output ubx_pkg::t_result      o_result
);
    import ubx_pkg::*;

    // remaining count holds length + 2 at most
    localparam int RW = $clog2(MAX_PAYLOAD + 3);
    localparam logic [7:0]    MAX_LEN = 8'(MAX_PAYLOAD);
    localparam logic [RW-1:0] REM_TWO = RW'(2);
    localparam logic [RW-1:0] REM_ONE = RW'(1);

    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_SYNC1 = 3'd1,
        PH_SYNC2 = 3'd2,
        PH_CLASS = 3'd3,
        PH_IDENT = 3'd4,
        PH_LENLO = 3'd5,
        PH_BODY  = 3'd6
    } t_phase;

    t_phase        r_phase,  n_phase;
    logic [7:0]    r_class,  n_class;
    logic [7:0]    r_ident,  n_ident;
    logic [5:0]    r_len,    n_len;
    logic [RW-1:0] r_rem,    n_rem;
    logic [7:0]    r_sum_a,  n_sum_a;
    logic [7:0]    r_sum_b,  n_sum_b;
    logic [7:0]    r_ck_a,   n_ck_a;
    logic [5:0]    r_pos,    n_pos;
    t_result       w_res;

    always_comb begin
        n_phase = r_phase;
        n_class = r_class;
        n_ident = r_ident;
        n_len   = r_len;
        n_rem   = r_rem;
        n_sum_a = r_sum_a;
        n_sum_b = r_sum_b;
        n_ck_a  = r_ck_a;
        n_pos   = r_pos;
        w_res   = '0;
        w_res.evt = EV_NONE;

        unique case (r_phase)
            PH_SYNC1: begin
                n_phase = (i_rx_byte == SYNC_SECOND) ? PH_SYNC2 : PH_HUNT;
            end
            PH_SYNC2: begin
                // class byte restarts the checksum
                n_class = i_rx_byte;
                n_sum_a = i_rx_byte;
                n_sum_b = i_rx_byte;
                n_phase = PH_CLASS;
            end
            PH_CLASS: begin
                n_ident = i_rx_byte;
                n_sum_a = r_sum_a + i_rx_byte;
                n_sum_b = r_sum_b + n_sum_a;
                n_phase = PH_IDENT;
            end
            PH_IDENT: begin
                if (i_rx_byte <= MAX_LEN) begin
                    n_len   = i_rx_byte[5:0];
                    n_rem   = RW'(i_rx_byte) + REM_TWO;
                    n_pos   = '0;
                    n_sum_a = r_sum_a + i_rx_byte;
                    n_sum_b = r_sum_b + n_sum_a;
                    n_phase = PH_LENLO;
                end else begin
                    w_res.evt       = EV_REJECT;
                    w_res.msg_class = r_class;
                    w_res.msg_ident = r_ident;
                    n_phase         = PH_HUNT;
                end
            end
            PH_LENLO: begin
                if (i_rx_byte == 8'h00) begin
                    // adding zero leaves sum_a as is
                    n_sum_b = r_sum_b + r_sum_a;
                    n_phase = PH_BODY;
                end else begin
                    w_res.evt         = EV_REJECT;
                    w_res.msg_class   = r_class;
                    w_res.msg_ident   = r_ident;
                    w_res.payload_len = r_len;
                    n_phase           = PH_HUNT;
                end
            end
            PH_BODY: begin
                w_res.msg_class   = r_class;
                w_res.msg_ident   = r_ident;
                w_res.payload_len = r_len;
                if (r_rem > REM_TWO) begin
                    n_sum_a             = r_sum_a + i_rx_byte;
                    n_sum_b             = r_sum_b + n_sum_a;
                    w_res.evt           = EV_PAYLOAD;
                    w_res.payload_byte  = i_rx_byte;
                    w_res.payload_index = r_pos;
                    n_pos               = r_pos + 6'd1;
                    n_rem               = r_rem - REM_ONE;
                end else if (r_rem == REM_TWO) begin
                    // first check byte reports nothing
                    n_ck_a            = i_rx_byte;
                    n_rem             = REM_ONE;
                    w_res.msg_class   = '0;
                    w_res.msg_ident   = '0;
                    w_res.payload_len = '0;
                end else begin
                    w_res.evt = (r_ck_a == r_sum_a && i_rx_byte == r_sum_b) ? EV_GOOD : EV_BAD;
                    n_rem     = '0;
                    n_phase   = PH_HUNT;
                end
            end
            default: begin
                n_phase = (i_rx_byte == SYNC_FIRST) ? PH_SYNC1 : PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_class <= '0;
            r_ident <= '0;
            r_len   <= '0;
            r_rem   <= '0;
            r_sum_a <= '0;
            r_sum_b <= '0;
            r_ck_a  <= '0;
            r_pos   <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_class <= n_class;
            r_ident <= n_ident;
            r_len   <= n_len;
            r_rem   <= n_rem;
            r_sum_a <= n_sum_a;
            r_sum_b <= n_sum_b;
            r_ck_a  <= n_ck_a;
            r_pos   <= n_pos;
        end
    end

    assign o_result = w_res;

endmodule

`default_nettype wire

// ----- design/ubx_out_buf.sv -----
`default_nettype none

module ubx_out_buf (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr,
    input  wire ubx_pkg::t_result i_data,
    output logic                  o_full,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output ubx_pkg::t_result      o_data
);
    import ubx_pkg::*;

    t_result    r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       w_rd;

    assign o_valid = (r_count != 2'd0);
    assign o_full  = r_count[1];
    assign w_rd    = o_valid && !i_stall;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_rd) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + {1'b0, i_wr} - {1'b0, w_rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ----- design/ubx_frame_parser.sv -----
// UBX frame parser: takes one serial byte per word on the input channel and gives one result
// word per byte. A byte is taken every cycle unless the input stalls; its result goes into a
// two-entry output buffer as it is taken, and the input stalls only while both entries hold
// undelivered results. The sync hunt, header checks and Fletcher-8 update all sit in the
// combinational next-state logic of the parse core, so throughput is one byte per clock while unstalled.
// Result words carry an event code (payload byte, frame good, checksum bad, header rejected)
// with the class, id and length of the frame; payload bytes come with their index.
// MAX_PAYLOAD bounds the accepted length low byte; length and index report modulo 64.
`default_nettype none

module ubx_frame_parser #(
    parameter int MAX_PAYLOAD = 62
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [2:0]      o_event_res,
    output logic [7:0]      o_msg_class,
    output logic [7:0]      o_msg_ident,
    output logic [5:0]      o_payload_len,
    output logic [7:0]      o_payload_byte,
    output logic [5:0]      o_payload_index
);
    import ubx_pkg::*;

    logic    w_accept;
    logic    w_full;
    t_result w_core_res;
    t_result w_out;

    assign o_stall  = w_full;
    assign w_accept = i_valid && !w_full;

    ubx_parse_core #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_rx_byte (i_rx_byte),
        .o_result  (w_core_res)
    );

    ubx_out_buf u_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_accept),
        .i_data  (w_core_res),
        .o_full  (w_full),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (w_out)
    );

    assign o_event_res     = w_out.evt;
    assign o_msg_class     = w_out.msg_class;
    assign o_msg_ident     = w_out.msg_ident;
    assign o_payload_len   = w_out.payload_len;
    assign o_payload_byte  = w_out.payload_byte;
    assign o_payload_index = w_out.payload_index;

endmodule

`default_nettype wire

// ----- design/ubx_checker.sv -----
`default_nettype none

`include "ubx_frame_parser_defines.svh"

module ubx_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic [2:0] o_event_res,
    input wire logic [7:0] o_msg_class,
    input wire logic [7:0] o_msg_ident,
    input wire logic [5:0] o_payload_len,
    input wire logic [7:0] o_payload_byte,
    input wire logic [5:0] o_payload_index
);
    import ubx_pkg::*;

    logic        w_quiet;
    logic        w_no_payload;
    logic        w_known;
    logic [38:0] w_word;

    assign w_quiet = (o_msg_class == 8'h00) && (o_msg_ident == 8'h00)
                  && (o_payload_len == 6'd0) && (o_payload_byte == 8'h00)
                  && (o_payload_index == 6'd0);
    assign w_no_payload = (o_event_res == EV_GOOD) || (o_event_res == EV_BAD)
                       || (o_event_res == EV_REJECT);
    assign w_known = (o_event_res == EV_NONE) || (o_event_res == EV_PAYLOAD)
                  || w_no_payload;
    assign w_word = {o_event_res, o_msg_class, o_msg_ident, o_payload_len,
                     o_payload_byte, o_payload_index};

    // buffer empties on reset
    `UBX_ASSERT_RESET(a_reset_empty, !i_rst_n, !o_valid, "output valid after reset")
    // a waiting result word holds
    `UBX_ASSERT_NEXT(a_hold, o_valid && i_stall, o_valid && $stable(w_word), "stalled result changed")
    `UBX_ASSERT_SAME(a_quiet, o_valid && (o_event_res == EV_NONE), w_quiet, "idle word not zero")
    `UBX_ASSERT_SAME(a_ev_fields, o_valid && w_no_payload, w_quiet || (o_payload_byte == 8'h00) && (o_payload_index == 6'd0), "payload fields set on frame event")
    `UBX_ASSERT_SAME(a_ev_code, o_valid, w_known, "unknown event code")

endmodule

bind ubx_frame_parser ubx_checker u_checker (.*);

`default_nettype wire
